### hw/rtl/bar_pkg.sv
// package: shared types and constants of the barometer compensation block
`default_nettype none
package bar_pkg;

   localparam int unsigned DIV_STAGES = 64;

   localparam logic [31:0] TEMP_ROUND  = 32'd128;
   localparam logic [32:0] FINE_OFFSET = 33'd128000;
   localparam logic [20:0] PRES_BASE   = 21'd1048576;
   localparam logic [11:0] PRES_SCALE  = 12'd3125;
   localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

   localparam logic [1:0] REG_TEMP       = 2'd0;
   localparam logic [1:0] REG_PRES_LOW   = 2'd1;
   localparam logic [1:0] REG_PRES_HIGH  = 2'd2;
   localparam logic [1:0] REG_PRES_LAST  = 2'd3;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [31:0] tc;
      logic [31:0] fine;
      logic        neg;
      logic        zero;
   } side_type;

endpackage
`default_nettype wire

### hw/rtl/bar_req_if.sv
// interface: request channel carrying raw readings
`default_nettype none
interface bar_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface
`default_nettype wire

### hw/rtl/bar_rsp_if.sv
// interface: response channel carrying compensated values
`default_nettype none
interface bar_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic signed [31:0] fine_temperature;
   logic signed [31:0] pressure_q8;
   logic               pressure_valid;
   modport source (output valid, temperature_centi, fine_temperature, pressure_q8,
                   pressure_valid, input ready);
   modport sink   (input valid, temperature_centi, fine_temperature, pressure_q8,
                   pressure_valid, output ready);
endinterface
`default_nettype wire

### hw/rtl/bar_csr.sv
// module: calibration coefficient registers behind the apb port
`default_nettype none
module bar_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [63:0]       pwdata,
   output logic      [63:0]       prdata,
   output logic                   pready,
   output bar_pkg::coeff_type     coeff
);
   logic [47:0] temp_ff;
   logic [63:0] plow_ff;
   logic [63:0] phigh_ff;
   logic [15:0] p9_ff;
   logic [1:0]  index;
   logic        wr;

   assign index  = paddr[4:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         plow_ff  <= '0;
         phigh_ff <= '0;
         p9_ff    <= '0;
      end else if (wr) begin
         unique case (index)
            bar_pkg::REG_TEMP:      temp_ff  <= pwdata[47:0];
            bar_pkg::REG_PRES_LOW:  plow_ff  <= pwdata;
            bar_pkg::REG_PRES_HIGH: phigh_ff <= pwdata;
            bar_pkg::REG_PRES_LAST: p9_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bar_pkg::REG_TEMP:      prdata = {16'd0, temp_ff};
         bar_pkg::REG_PRES_LOW:  prdata = plow_ff;
         bar_pkg::REG_PRES_HIGH: prdata = phigh_ff;
         bar_pkg::REG_PRES_LAST: prdata = {48'd0, p9_ff};
         default:                prdata = '0;
      endcase
   end

   assign coeff.t1 = temp_ff[15:0];
   assign coeff.t2 = temp_ff[31:16];
   assign coeff.t3 = temp_ff[47:32];
   assign coeff.p1 = plow_ff[15:0];
   assign coeff.p2 = plow_ff[31:16];
   assign coeff.p3 = plow_ff[47:32];
   assign coeff.p4 = plow_ff[63:48];
   assign coeff.p5 = phigh_ff[15:0];
   assign coeff.p6 = phigh_ff[31:16];
   assign coeff.p7 = phigh_ff[47:32];
   assign coeff.p8 = phigh_ff[63:48];
   assign coeff.p9 = p9_ff;
endmodule
`default_nettype wire

### hw/rtl/bar_front.sv
// module: temperature path and pressure divider operand stages
`default_nettype none
module bar_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire bar_pkg::coeff_type coeff,
   input  wire logic               in_valid,
   input  wire logic [19:0]        raw_t,
   input  wire logic [19:0]        raw_p,
   output logic                    out_valid,
   output logic [63:0]             num_mag,
   output logic [30:0]             den_mag,
   output bar_pkg::side_type       side
);
   logic [9:0] v_ff;

   // stage 1
   logic signed [17:0] x1;
   logic signed [16:0] dt;
   logic signed [33:0] x1t2;
   logic signed [33:0] dd;
   logic [31:0] s1_a_ff, s1_dd_ff;
   logic [19:0] s1_p_ff;
   // stage 2
   logic signed [31:0] a_in, ddd;
   logic signed [47:0] bprod;
   logic [31:0] s2_a_ff, s2_b_ff;
   logic [19:0] s2_p_ff;
   // stage 3
   logic signed [31:0] b_sh;
   logic [31:0] s3_fine_ff;
   logic [19:0] s3_p_ff;
   // stage 4
   logic signed [32:0] v1_in;
   logic [31:0] tcp_in;
   logic signed [32:0] s4_v1_ff;
   logic [31:0] s4_tcp_ff, s4_fine_ff;
   logic [19:0] s4_p_ff;
   // stage 5
   logic signed [65:0] sq_full;
   logic signed [48:0] m5, m2;
   logic signed [31:0] tc_in;
   logic [63:0] s5_sq_ff;
   logic signed [48:0] s5_m5_ff, s5_m2_ff;
   logic [31:0] s5_tc_ff, s5_fine_ff;
   logic [19:0] s5_p_ff;
   // stage 6
   logic signed [79:0] sqp6, sqp3;
   logic [63:0] t17_in;
   logic [63:0] s6_sqp6_ff, s6_sqp3_ff, s6_t17_ff;
   logic signed [48:0] s6_m2_ff;
   logic [31:0] s6_tc_ff, s6_fine_ff;
   logic [19:0] s6_p_ff;
   // stage 7
   logic signed [63:0] sqp3_sh;
   logic [63:0] s7_v2_ff, s7_v1_ff;
   logic [31:0] s7_tc_ff, s7_fine_ff;
   logic [19:0] s7_p_ff;
   // stage 8
   logic [20:0] pbase;
   logic [63:0] s8_base_ff, s8_num_ff;
   logic [31:0] s8_tc_ff, s8_fine_ff;
   // stage 9
   logic [79:0] bp1;
   logic [75:0] n3125;
   logic [63:0] s9_den_ff, s9_num_ff;
   logic [31:0] s9_tc_ff, s9_fine_ff;
   // stage 10
   logic [30:0] den31;
   logic        den_neg, num_neg;
   logic [63:0] num_mag_ff;
   logic [30:0] den_mag_ff;
   bar_pkg::side_type side_ff;

   assign x1   = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
   assign dt   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coeff.t1});
   assign x1t2 = x1 * coeff.t2;
   assign dd   = dt * dt;

   assign a_in  = $signed(s1_a_ff) >>> 11;
   assign ddd   = $signed(s1_dd_ff) >>> 12;
   assign bprod = ddd * coeff.t3;

   assign b_sh = $signed(s2_b_ff) >>> 14;

   assign v1_in  = $signed({s3_fine_ff[31], s3_fine_ff}) - $signed(bar_pkg::FINE_OFFSET);
   assign tcp_in = {s3_fine_ff[29:0], 2'b00} + s3_fine_ff + bar_pkg::TEMP_ROUND;

   assign sq_full = s4_v1_ff * s4_v1_ff;
   assign m5      = s4_v1_ff * coeff.p5;
   assign m2      = s4_v1_ff * coeff.p2;
   assign tc_in   = $signed(s4_tcp_ff) >>> 8;

   assign sqp6   = $signed(s5_sq_ff) * coeff.p6;
   assign sqp3   = $signed(s5_sq_ff) * coeff.p3;
   assign t17_in = {s5_m5_ff[46:0], 17'd0} + {{13{coeff.p4[15]}}, coeff.p4, 35'd0};

   assign sqp3_sh = $signed(s6_sqp3_ff) >>> 8;

   assign pbase = bar_pkg::PRES_BASE - {1'b0, s7_p_ff};

   assign bp1   = s8_base_ff * {64'd0, coeff.p1};
   assign n3125 = s8_num_ff * {64'd0, bar_pkg::PRES_SCALE};

   assign den31   = s9_den_ff[63:33];
   assign den_neg = s9_den_ff[63];
   assign num_neg = s9_num_ff[63];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff  <= x1t2[31:0];
         s1_dd_ff <= dd[31:0];
         s1_p_ff  <= raw_p;

         s2_a_ff <= a_in;
         s2_b_ff <= bprod[31:0];
         s2_p_ff <= s1_p_ff;

         s3_fine_ff <= s2_a_ff + b_sh;
         s3_p_ff    <= s2_p_ff;

         s4_v1_ff   <= v1_in;
         s4_tcp_ff  <= tcp_in;
         s4_fine_ff <= s3_fine_ff;
         s4_p_ff    <= s3_p_ff;

         s5_sq_ff   <= sq_full[63:0];
         s5_m5_ff   <= m5;
         s5_m2_ff   <= m2;
         s5_tc_ff   <= tc_in;
         s5_fine_ff <= s4_fine_ff;
         s5_p_ff    <= s4_p_ff;

         s6_sqp6_ff <= sqp6[63:0];
         s6_sqp3_ff <= sqp3[63:0];
         s6_t17_ff  <= t17_in;
         s6_m2_ff   <= s5_m2_ff;
         s6_tc_ff   <= s5_tc_ff;
         s6_fine_ff <= s5_fine_ff;
         s6_p_ff    <= s5_p_ff;

         s7_v2_ff   <= s6_sqp6_ff + s6_t17_ff;
         s7_v1_ff   <= sqp3_sh + {{3{s6_m2_ff[48]}}, s6_m2_ff[48:0], 12'd0};
         s7_tc_ff   <= s6_tc_ff;
         s7_fine_ff <= s6_fine_ff;
         s7_p_ff    <= s6_p_ff;

         s8_base_ff <= bar_pkg::V1_BIAS + s7_v1_ff;
         s8_num_ff  <= {12'd0, pbase[20:0], 31'd0} - s7_v2_ff;
         s8_tc_ff   <= s7_tc_ff;
         s8_fine_ff <= s7_fine_ff;

         s9_den_ff  <= bp1[63:0];
         s9_num_ff  <= n3125[63:0];
         s9_tc_ff   <= s8_tc_ff;
         s9_fine_ff <= s8_fine_ff;

         num_mag_ff   <= num_neg ? (64'd0 - s9_num_ff) : s9_num_ff;
         den_mag_ff   <= den_neg ? (31'd0 - den31) : den31;
         side_ff.tc   <= s9_tc_ff;
         side_ff.fine <= s9_fine_ff;
         side_ff.neg  <= num_neg ^ den_neg;
         side_ff.zero <= (den31 == 31'd0);
      end
   end

   assign out_valid = v_ff[9];
   assign num_mag   = num_mag_ff;
   assign den_mag   = den_mag_ff;
   assign side      = side_ff;
endmodule
`default_nettype wire

### hw/rtl/bar_divider.sv
// module: pipelined restoring divider, one quotient bit per stage
`default_nettype none
module bar_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [63:0]       num,
   input  wire logic [30:0]       den,
   input  wire bar_pkg::side_type in_side,
   output logic                   out_valid,
   output logic [63:0]            quot,
   output bar_pkg::side_type      out_side
);
   localparam int unsigned N = bar_pkg::DIV_STAGES;

   logic              v_ff    [N];
   logic [30:0]       rem_ff  [N];
   logic [63:0]       qd_ff   [N];
   logic [30:0]       den_ff  [N];
   bar_pkg::side_type side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              v_prev;
      logic [30:0]       rem_prev;
      logic [63:0]       qd_prev;
      logic [30:0]       den_prev;
      bar_pkg::side_type side_prev;
      logic [31:0]       trial;
      logic              ge;
      logic [31:0]       diff;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign qd_prev   = num;
         assign den_prev  = den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign qd_prev   = qd_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign trial = {rem_prev, qd_prev[63]};
      assign ge    = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[30:0] : trial[30:0];
            qd_ff[i]   <= {qd_prev[62:0], ge};
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign quot      = qd_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule
`default_nettype wire

### hw/rtl/bar_back.sv
// module: pressure correction, saturation and response register
`default_nettype none
module bar_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire bar_pkg::coeff_type coeff,
   input  wire logic               in_valid,
   input  wire logic [63:0]        quot,
   input  wire bar_pkg::side_type  side,
   output logic                    out_valid,
   output logic [31:0]             tc,
   output logic [31:0]             fine,
   output logic [31:0]             pres,
   output logic                    pres_ok
);
   logic [6:0] v_ff;

   logic [63:0] b1_p_ff;
   logic [31:0] b1_tc_ff, b1_fine_ff;
   logic        b1_ok_ff;

   logic signed [63:0] ps;
   logic [63:0] ll;
   logic [63:0] hl;
   logic signed [79:0] w2p;
   logic [63:0] b2_p_ff, b2_ll_ff, b2_w2p_ff;
   logic [31:0] b2_hl_ff, b2_tc_ff, b2_fine_ff;
   logic        b2_ok_ff;

   logic signed [63:0] w2_in;
   logic [63:0] b3_p_ff, b3_sq_ff, b3_w2_ff;
   logic [31:0] b3_tc_ff, b3_fine_ff;
   logic        b3_ok_ff;

   logic signed [79:0] w1p;
   logic [63:0] b4_p_ff, b4_w1p_ff, b4_w2_ff;
   logic [31:0] b4_tc_ff, b4_fine_ff;
   logic        b4_ok_ff;

   logic signed [63:0] w1_in;
   logic [63:0] b5_sum_ff;
   logic [31:0] b5_tc_ff, b5_fine_ff;
   logic        b5_ok_ff;

   logic signed [63:0] sum_sh;
   logic [63:0] b6_f_ff;
   logic [31:0] b6_tc_ff, b6_fine_ff;
   logic        b6_ok_ff;

   logic [31:0] sat_in;
   logic [31:0] pres_ff, tc_ff, fine_ff;
   logic        ok_ff;

   assign ps  = $signed(b1_p_ff) >>> 13;
   assign ll  = {32'd0, ps[31:0]} * {32'd0, ps[31:0]};
   assign hl  = {32'd0, ps[63:32]} * {32'd0, ps[31:0]};
   assign w2p = $signed(b1_p_ff) * coeff.p8;

   assign w2_in = $signed(b2_w2p_ff) >>> 19;

   assign w1p = $signed(b3_sq_ff) * coeff.p9;

   assign w1_in = $signed(b4_w1p_ff) >>> 25;

   assign sum_sh = $signed(b5_sum_ff) >>> 8;

   always_comb begin
      if (b6_f_ff[63:31] == {33{b6_f_ff[63]}}) begin
         sat_in = b6_f_ff[31:0];
      end else if (b6_f_ff[63]) begin
         sat_in = 32'h8000_0000;
      end else begin
         sat_in = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_p_ff    <= side.neg ? (64'd0 - quot) : quot;
         b1_tc_ff   <= side.tc;
         b1_fine_ff <= side.fine;
         b1_ok_ff   <= !side.zero;

         b2_p_ff    <= b1_p_ff;
         b2_ll_ff   <= ll;
         b2_hl_ff   <= hl[31:0];
         b2_w2p_ff  <= w2p[63:0];
         b2_tc_ff   <= b1_tc_ff;
         b2_fine_ff <= b1_fine_ff;
         b2_ok_ff   <= b1_ok_ff;

         b3_p_ff    <= b2_p_ff;
         b3_sq_ff   <= b2_ll_ff + {b2_hl_ff[30:0], 33'd0};
         b3_w2_ff   <= w2_in;
         b3_tc_ff   <= b2_tc_ff;
         b3_fine_ff <= b2_fine_ff;
         b3_ok_ff   <= b2_ok_ff;

         b4_p_ff    <= b3_p_ff;
         b4_w1p_ff  <= w1p[63:0];
         b4_w2_ff   <= b3_w2_ff;
         b4_tc_ff   <= b3_tc_ff;
         b4_fine_ff <= b3_fine_ff;
         b4_ok_ff   <= b3_ok_ff;

         b5_sum_ff  <= b4_p_ff + w1_in + b4_w2_ff;
         b5_tc_ff   <= b4_tc_ff;
         b5_fine_ff <= b4_fine_ff;
         b5_ok_ff   <= b4_ok_ff;

         b6_f_ff    <= sum_sh + {{44{coeff.p7[15]}}, coeff.p7, 4'd0};
         b6_tc_ff   <= b5_tc_ff;
         b6_fine_ff <= b5_fine_ff;
         b6_ok_ff   <= b5_ok_ff;

         pres_ff <= b6_ok_ff ? sat_in : 32'd0;
         tc_ff   <= b6_tc_ff;
         fine_ff <= b6_fine_ff;
         ok_ff   <= b6_ok_ff;
      end
   end

   assign out_valid = v_ff[6];
   assign tc        = tc_ff;
   assign fine      = fine_ff;
   assign pres      = pres_ff;
   assign pres_ok   = ok_ff;
endmodule
`default_nettype wire

### hw/rtl/barometer_reading_compensation.sv
// top level: integer compensation of raw barometric temperature and pressure
// requests carry a 20-bit raw temperature and a 20-bit raw pressure on req_chan
// each request gives one response on rsp_chan: temperature in centidegrees,
// fine temperature, pressure in pascal times 256 and a pressure valid flag
// pressure_valid is low and pressure_q8 zero when the pressure divisor is zero
// coefficients are written over the csr apb port at byte address 8*i, 64-bit data
// one request is taken per cycle while the pipeline advances; the response is presented
// after acceptance, through 81 register stages (10 operand, 64 divider, 7 correction)
// the 64-stage restoring divider, one quotient bit per stage, sets the latency
// the whole pipeline advances while the response register is empty or taken;
// when the receiver stalls every stage holds and req_chan.ready drops
// reset clears every valid bit and all coefficients to zero
`default_nettype none
module barometer_reading_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   bar_req_if.sink          req_chan,
   bar_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready
);
   bar_pkg::coeff_type coeff;
   bar_pkg::side_type  f_side, d_side;
   logic        en;
   logic        f_valid, d_valid, b_valid;
   logic [63:0] f_num, d_quot;
   logic [30:0] f_den;
   logic [31:0] b_tc, b_fine, b_pres;
   logic        b_ok;

   assign en             = !b_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   bar_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .coeff   (coeff)
   );

   bar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coeff     (coeff),
      .in_valid  (req_chan.valid),
      .raw_t     (req_chan.raw_temperature),
      .raw_p     (req_chan.raw_pressure),
      .out_valid (f_valid),
      .num_mag   (f_num),
      .den_mag   (f_den),
      .side      (f_side)
   );

   bar_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num       (f_num),
      .den       (f_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .quot      (d_quot),
      .out_side  (d_side)
   );

   bar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coeff     (coeff),
      .in_valid  (d_valid),
      .quot      (d_quot),
      .side      (d_side),
      .out_valid (b_valid),
      .tc        (b_tc),
      .fine      (b_fine),
      .pres      (b_pres),
      .pres_ok   (b_ok)
   );

   assign rsp_chan.valid             = b_valid;
   assign rsp_chan.temperature_centi = b_tc;
   assign rsp_chan.fine_temperature  = b_fine;
   assign rsp_chan.pressure_q8       = b_pres;
   assign rsp_chan.pressure_valid    = b_ok;
endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench: barometer compensation checked against an in-bench integer predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] fine_temperature;
      logic [31:0] pressure_q8;
      logic        pressure_valid;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   bar_req_if req_chan ();
   bar_rsp_if rsp_chan ();

   barometer_reading_compensation i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // coefficient copy kept by the bench
   logic [47:0] temp_coeffs;
   logic [63:0] pres_low;
   logic [63:0] pres_high;
   logic [15:0] pres_last;

   reading_type expected_readings[$];
   int          errors;
   int          requests_sent;
   int          readings_checked;
   int          invalid_seen;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_off_cycles;
   int          quiet_cycles;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 100;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [63:0] sext16(input logic [15:0] f);
      return {{48{f[15]}}, f};
   endfunction

   function automatic reading_type compensate(input logic [19:0] raw_t,
                                              input logic [19:0] raw_p);
      logic [31:0] adc, t1, t2, t3, x, a, d, b, fine;
      logic [63:0] v1, v2, w, p, ps, w1, w2, num, mag_n, mag_d, q;
      reading_type r;
      adc  = {12'd0, raw_t};
      t1   = {16'd0, temp_coeffs[15:0]};
      t2   = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
      t3   = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
      x    = ((adc >> 3) - (t1 << 1)) * t2;
      a    = $signed(x) >>> 11;
      d    = (adc >> 4) - t1;
      x    = d * d;
      x    = $signed(x) >>> 12;
      x    = x * t3;
      b    = $signed(x) >>> 14;
      fine = a + b;
      x    = fine * 32'd5 + 32'd128;
      r.temperature_centi = $signed(x) >>> 8;
      r.fine_temperature  = fine;

      v1 = {{32{fine[31]}}, fine} - 64'd128000;
      v2 = v1 * v1 * sext16(pres_high[31:16]);
      v2 = v2 + ((v1 * sext16(pres_high[15:0])) << 17);
      v2 = v2 + (sext16(pres_low[63:48]) << 35);
      w  = v1 * v1 * sext16(pres_low[47:32]);
      w  = $signed(w) >>> 8;
      v1 = w + ((v1 * sext16(pres_low[31:16])) << 12);
      w  = (64'h0000_8000_0000_0000 + v1) * {48'd0, pres_low[15:0]};
      v1 = $signed(w) >>> 33;

      if (v1 == 64'd0) begin
         r.pressure_q8    = 32'd0;
         r.pressure_valid = 1'b0;
      end else begin
         p     = 64'd1048576 - {44'd0, raw_p};
         num   = ((p << 31) - v2) * 64'd3125;
         mag_n = num[63] ? 64'd0 - num : num;
         mag_d = v1[63] ? 64'd0 - v1 : v1;
         q     = mag_n / mag_d;
         p     = (num[63] ^ v1[63]) ? 64'd0 - q : q;
         ps    = $signed(p) >>> 13;
         w     = sext16(pres_last) * ps * ps;
         w1    = $signed(w) >>> 25;
         w     = sext16(pres_high[63:48]) * p;
         w2    = $signed(w) >>> 19;
         w     = p + w1 + w2;
         p     = $signed(w) >>> 8;
         p     = p + (sext16(pres_high[47:32]) << 4);
         if ($signed(p) < -64'sd2147483648)
            p = 64'hFFFF_FFFF_8000_0000;
         else if ($signed(p) > 64'sd2147483647)
            p = 64'h0000_0000_7FFF_FFFF;
         r.pressure_q8    = p[31:0];
         r.pressure_valid = 1'b1;
      end
      return r;
   endfunction

   // all tasks start and end just after a falling edge
   task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid           = 1'b1;
      req_chan.raw_temperature = raw_t;
      req_chan.raw_pressure    = raw_p;
      do
         @(posedge clock);
      while (!req_chan.ready);
      expected_readings.push_back(compensate(raw_t, raw_p));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_chan.valid = 1'b0;
      while (expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (index)
         bar_pkg::REG_TEMP:      temp_coeffs = value[47:0];
         bar_pkg::REG_PRES_LOW:  pres_low    = value;
         bar_pkg::REG_PRES_HIGH: pres_high   = value;
         bar_pkg::REG_PRES_LAST: pres_last   = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_coeffs(input logic [63:0] t, input logic [63:0] pl,
                              input logic [63:0] ph, input logic [63:0] p9);
      drain_pipeline();
      write_register(bar_pkg::REG_TEMP, t);
      write_register(bar_pkg::REG_PRES_LOW, pl);
      write_register(bar_pkg::REG_PRES_HIGH, ph);
      write_register(bar_pkg::REG_PRES_LAST, p9);
   endtask

   task automatic load_typical_coeffs();
      load_coeffs({16'h0, 16'hFC18, 16'h6743, 16'h6B70},
                  {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                  64'd6000);
   endtask

   task automatic send_edge_readings();
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h00000, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'h00000);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'h55555, 20'hAAAAA);
   endtask

   task automatic send_random_reading();
      if ($urandom_range(99) < 70)
         send_reading(20'd400000 + 20'($urandom_range(200000)),
                      20'd200000 + 20'($urandom_range(400000)));
      else
         send_reading(20'($urandom), 20'($urandom));
   endtask

   task automatic test_reset_coeffs();
      // zero coefficients give a zero divisor
      send_edge_readings();
   endtask

   task automatic test_directed_coeffs();
      load_typical_coeffs();
      send_edge_readings();
      load_coeffs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_edge_readings();
      load_coeffs(64'h0000_8000_8000_8000, 64'h8000_8000_8000_8000,
                  64'h8000_8000_8000_8000, 64'h8000);
      send_edge_readings();
      load_coeffs(64'h0000_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
      send_edge_readings();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input bit random_coeffs);
      if (random_coeffs)
         load_coeffs({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      else
         load_coeffs({16'h0, 16'($urandom_range(16'hFC00, 16'hFFFF)),
                      16'($urandom_range(20000, 30000)), 16'($urandom_range(26000, 30000))},
                     {16'($urandom_range(2000, 4000)), 16'($urandom_range(2000, 4000)),
                      16'hD643, 16'($urandom_range(30000, 40000))},
                     {16'hC6F8, 16'($urandom_range(14000, 16000)), 16'hFFF9,
                      16'($urandom_range(0, 300))},
                     64'($urandom_range(0, 8000)));
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (170) send_random_reading();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      load_typical_coeffs();
      hold_off_cycles = 400;
      repeat (120) send_random_reading();
   endtask

   task automatic test_pause_until_empty();
      repeat (20) send_random_reading();
      req_chan.valid = 1'b0;
      while (expected_readings.size() != 0)
         @(negedge clock);
      repeat (20) send_random_reading();
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_chan.ready = 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // checker
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected response tc=%0d fine=%0d p=%0d pv=%0b", $time,
                     rsp_chan.temperature_centi, rsp_chan.fine_temperature,
                     rsp_chan.pressure_q8, rsp_chan.pressure_valid);
            errors++;
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            if (!want.pressure_valid)
               invalid_seen++;
            if (rsp_chan.temperature_centi !== want.temperature_centi) begin
               $display("%0t: temperature_centi expected %0d actual %0d", $time,
                        $signed(want.temperature_centi), rsp_chan.temperature_centi);
               errors++;
            end
            if (rsp_chan.fine_temperature !== want.fine_temperature) begin
               $display("%0t: fine_temperature expected %0d actual %0d", $time,
                        $signed(want.fine_temperature), rsp_chan.fine_temperature);
               errors++;
            end
            if (rsp_chan.pressure_q8 !== want.pressure_q8) begin
               $display("%0t: pressure_q8 expected %0d actual %0d", $time,
                        $signed(want.pressure_q8), rsp_chan.pressure_q8);
               errors++;
            end
            if (rsp_chan.pressure_valid !== want.pressure_valid) begin
               $display("%0t: pressure_valid expected %0b actual %0b", $time,
                        want.pressure_valid, rsp_chan.pressure_valid);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.raw_temperature = 20'd0;
      req_chan.raw_pressure    = 20'd0;
      rsp_chan.ready           = 1'b0;
      csr_psel                 = 1'b0;
      csr_penable              = 1'b0;
      csr_pwrite               = 1'b0;
      csr_paddr                = 5'd0;
      csr_pwdata               = 64'd0;
      temp_coeffs              = 48'd0;
      pres_low                 = 64'd0;
      pres_high                = 64'd0;
      pres_last                = 16'd0;
      errors                   = 0;
      requests_sent            = 0;
      readings_checked         = 0;
      invalid_seen             = 0;
      sender_idle_pct          = 0;
      receiver_stall_pct       = 0;
      hold_off_cycles          = 0;
      quiet_cycles             = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_coeffs();
      test_directed_coeffs();
      test_random_traffic(0, 0, 1'b0);
      test_random_traffic(72, 0, 1'b1);
      test_random_traffic(0, 72, 1'b0);
      test_random_traffic(35, 35, 1'b1);
      test_backpressure();
      test_pause_until_empty();
      drain_pipeline();

      $display("%0d requests sent, %0d responses checked, %0d with zero divisor",
               requests_sent, readings_checked, invalid_seen);
      $display("covered reset, edge, saturating and random coefficients under idling and stalls");
      if (errors == 0 && expected_readings.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/bar_pkg.sv
hw/rtl/bar_req_if.sv
hw/rtl/bar_rsp_if.sv
hw/rtl/bar_csr.sv
hw/rtl/bar_front.sv
hw/rtl/bar_divider.sv
hw/rtl/bar_back.sv
hw/rtl/barometer_reading_compensation.sv
tb/tb_top.sv
